>>> hw/rtl/bounded_list_with_search_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded list block
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LIST_WITH_SEARCH_ASSERT_SVH
`define BOUNDED_LIST_WITH_SEARCH_ASSERT_SVH

// same-cycle implication, masked during reset
`define LST_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, masked during reset
`define LST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/lst_pkg.sv
// ----------------------------------------------------------------------------
// lst_pkg
// Constants, operation and status codes, and the control bundle shared by
// the list cells and the top level.
// ----------------------------------------------------------------------------
package lst_pkg;

  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int FUNC_W = 3;
  localparam int STAT_W = 2;

  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_REMOVE     = 3'd4;
  localparam logic [FUNC_W-1:0] FN_FIND       = 3'd5;
  localparam logic [FUNC_W-1:0] FN_CLEAR      = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISS  = 2'd3;

  // broadcast to every cell; at most one operation bit is set
  typedef struct packed {
    logic                     push_front;
    logic                     push_back;
    logic                     pop_front;
    logic                     pop_back;
    logic                     remove;
    logic                     clear;
    logic signed [DATA_W-1:0] value;
  } lst_ctrl_t;

endpackage

>>> hw/rtl/lst_cell.sv
// ----------------------------------------------------------------------------
// lst_cell
// One list position: holds an entry and its occupied bit, compares against
// the broadcast value and shifts towards either neighbour.
// ----------------------------------------------------------------------------
module lst_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  lst_pkg::lst_ctrl_t               ctrl,
  input  logic signed [lst_pkg::DATA_W-1:0] left_data,
  input  logic                             left_occ,
  input  logic signed [lst_pkg::DATA_W-1:0] right_data,
  input  logic                             right_occ,
  input  logic                             hit_in,
  output logic signed [lst_pkg::DATA_W-1:0] data,
  output logic                             occ,
  output logic                             hit_out
);
  import lst_pkg::*;

  logic match;

  assign match   = occ && (data == ctrl.value);
  assign hit_out = hit_in || match;

  // occupancy forms a thermometer from the front
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      priority if (ctrl.clear) begin
        occ <= 1'b0;
      end else if (ctrl.push_front) begin
        occ <= left_occ;
      end else if (ctrl.push_back) begin
        if (!occ && left_occ) begin
          occ <= 1'b1;
        end
      end else if (ctrl.pop_front || ctrl.pop_back || (ctrl.remove && hit_out)) begin
        occ <= right_occ;
      end else begin
        occ <= occ;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (ctrl.push_front) begin
      data <= left_data;
    end else if (ctrl.push_back && !occ && left_occ) begin
      data <= ctrl.value;
    end else if (ctrl.pop_front || (ctrl.remove && hit_out)) begin
      data <= right_data;
    end else begin
      data <= data;
    end
  end

endmodule

>>> hw/rtl/bounded_list_with_search.sv
// ----------------------------------------------------------------------------
// bounded_list_with_search
// Ordered list of signed 32-bit entries in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Command side: drive func and value with start high; the item is taken
//   at the clock edge where start is high and busy is low. busy stays low,
//   so one item may be issued every cycle.
//   Result side: in the cycle after the item is taken, valid pulses for a
//   single cycle with found, count, is_empty and status. The receiver must
//   take it then; there is no way to hold a result back.
//   Throughput is one item per cycle. The whole item is settled in the
//   cycle it is taken by the cell row: every cell compares its entry
//   with value at once, a first-match flag ripples from front to back, and
//   each cell then loads itself, a neighbour's entry or the new value.
//   Reset clears the occupied bit of every cell and the entry count; entry
//   contents are left as they are and only become visible once written.
//   Pushes into a full list are dropped with status full; pops and removes
//   on an empty list change nothing and report status empty.
// ----------------------------------------------------------------------------
module bounded_list_with_search (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [lst_pkg::FUNC_W-1:0]        func,
  input  logic signed [lst_pkg::DATA_W-1:0] value,
  output logic                              valid,
  output logic                              found,
  output logic [lst_pkg::CNT_W-1:0]         count,
  output logic                              is_empty,
  output logic [lst_pkg::STAT_W-1:0]        status
);
  import lst_pkg::*;

  logic                     accept;
  logic                     list_empty;
  logic                     list_full;
  lst_ctrl_t                ctrl;
  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic                     cell_occ  [DEPTH];
  logic                     hit       [DEPTH+1];
  logic [CNT_W-1:0]         entry_count;
  logic [CNT_W-1:0]         entry_count_next;
  logic                     found_next;
  logic [STAT_W-1:0]        status_next;

  // every item completes in its accept cycle, so never hold the sender off
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign list_empty = (entry_count == '0);
  assign list_full  = (entry_count == CNT_W'(DEPTH));

  // decode the item into the broadcast bundle; drop illegal pushes and pops here
  always_comb begin
    ctrl            = '0;
    ctrl.value      = value;
    if (accept) begin
      ctrl.push_front = (func == FN_PUSH_FRONT) && !list_full;
      ctrl.push_back  = (func == FN_PUSH_BACK)  && !list_full;
      ctrl.pop_front  = (func == FN_POP_FRONT)  && !list_empty;
      ctrl.pop_back   = (func == FN_POP_BACK)   && !list_empty;
      ctrl.remove     = (func == FN_REMOVE);
      ctrl.clear      = (func == FN_CLEAR);
    end
  end

  // first-match flag enters at the front with nothing seen
  assign hit[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_row
    logic signed [DATA_W-1:0] left_data;
    logic                     left_occ;
    logic signed [DATA_W-1:0] right_data;
    logic                     right_occ;

    if (i == 0) begin : g_front
      // front cell takes the new value on push front and sees an occupied left
      assign left_data = value;
      assign left_occ  = 1'b1;
    end else begin : g_mid
      assign left_data = cell_data[i-1];
      assign left_occ  = cell_occ[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign right_data = '0;
      assign right_occ  = 1'b0;
    end else begin : g_inner
      assign right_data = cell_data[i+1];
      assign right_occ  = cell_occ[i+1];
    end

    lst_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .left_data  (left_data),
      .left_occ   (left_occ),
      .right_data (right_data),
      .right_occ  (right_occ),
      .hit_in     (hit[i]),
      .data       (cell_data[i]),
      .occ        (cell_occ[i]),
      .hit_out    (hit[i+1])
    );
  end

  // count and status for the item being taken
  always_comb begin
    entry_count_next = entry_count;
    found_next       = 1'b0;
    status_next      = ST_OK;
    unique case (func)
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        if (list_full) begin
          status_next = ST_FULL;
        end else begin
          entry_count_next = entry_count + CNT_W'(1);
        end
      end
      FN_POP_FRONT, FN_POP_BACK: begin
        if (list_empty) begin
          status_next = ST_EMPTY;
        end else begin
          entry_count_next = entry_count - CNT_W'(1);
        end
      end
      FN_REMOVE: begin
        priority if (list_empty) begin
          status_next = ST_EMPTY;
        end else if (hit[DEPTH]) begin
          found_next       = 1'b1;
          entry_count_next = entry_count - CNT_W'(1);
        end else begin
          status_next = ST_MISS;
        end
      end
      FN_FIND: begin
        if (hit[DEPTH]) begin
          found_next = 1'b1;
        end else begin
          status_next = ST_MISS;
        end
      end
      FN_CLEAR: begin
        entry_count_next = '0;
      end
      default: begin
        // unused code: change nothing, report ok
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      valid       <= 1'b0;
    end else begin
      valid <= accept;
      if (accept) begin
        entry_count <= entry_count_next;
      end
    end
  end

  // result payload: hold until the next item overwrites it
  always_ff @(posedge clk) begin
    if (accept) begin
      found    <= found_next;
      count    <= entry_count_next;
      is_empty <= (entry_count_next == '0);
      status   <= status_next;
    end
  end

endmodule

>>> hw/rtl/lst_checker.sv
// ----------------------------------------------------------------------------
// lst_checker
// Port-level checks on the bounded list, bound to the top level.
// ----------------------------------------------------------------------------
`include "bounded_list_with_search_assert.svh"

module lst_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              valid,
  input logic                              found,
  input logic [lst_pkg::CNT_W-1:0]         count,
  input logic                              is_empty,
  input logic [lst_pkg::STAT_W-1:0]        status
);
  import lst_pkg::*;

  // each item taken gives a result in the next cycle
  `LST_ASSERT_NEXT(a_result_follows, clk, rst, start && !busy, valid)
  `LST_ASSERT_IMPLY(a_count_bound, clk, rst, valid, count <= CNT_W'(DEPTH))
  `LST_ASSERT_IMPLY(a_empty_flag, clk, rst, valid, is_empty == (count == '0))
  `LST_ASSERT_IMPLY(a_found_ok, clk, rst, valid && found, status == ST_OK)
  `LST_ASSERT_IMPLY(a_full_count, clk, rst, valid && (status == ST_FULL),
                    count == CNT_W'(DEPTH))

endmodule

bind bounded_list_with_search lst_checker u_lst_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .valid    (valid),
  .found    (found),
  .count    (count),
  .is_empty (is_empty),
  .status   (status)
);
